### rtl/tc8_pkg.sv
`default_nettype none

package tc8_pkg;

  // Counter, prescaler and configuration widths
  localparam int CNT_BITS = 8;
  localparam int PRE_BITS = 10;
  localparam int CFG_BITS = 8;
  localparam int CFG_INDEX_BITS = 3;

  // Stream payload widths, rounded up to whole bytes
  localparam int IN_FIELD_BITS = 9;
  localparam int IN_DATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 13;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int FUNC_BITS = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_FORCE_A = 2'd2,
    FUNC_FORCE_B = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLOCK_SELECT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTION_A     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTION_B     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMPARE_A    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMPARE_B    = 3'd5;

  // Clock select codes
  localparam logic [2:0] CS_STOP    = 3'd0;
  localparam logic [2:0] CS_DIV1    = 3'd1;
  localparam logic [2:0] CS_DIV8    = 3'd2;
  localparam logic [2:0] CS_DIV64   = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;
  localparam logic [2:0] CS_EXT_FALL = 3'd6;
  localparam logic [2:0] CS_EXT_RISE = 3'd7;

  // Waveform mode codes
  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_CTC     = 3'd2;
  localparam logic [2:0] MODE_RSVD_LO = 3'd4;
  localparam logic [2:0] MODE_RSVD_HI = 3'd6;

  // Compare output actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_TOGGLE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_SET    = 2'd3;

  // Status flag bit positions
  localparam int FLAG_OVF = 0;
  localparam int FLAG_MA  = 1;
  localparam int FLAG_MB  = 2;

  typedef struct packed {
    logic [CNT_BITS-1:0] counter;
    logic [PRE_BITS-1:0] prescale;
    logic                ext_prev;
    logic                written_last;
    logic [2:0]          flags;
    logic [1:0]          pins;
  } tc8_state_t;

  function automatic logic apply_action(input logic [1:0] action, input logic level);
    logic result;
    case (action)
      ACT_TOGGLE: result = ~level;
      ACT_CLEAR:  result = 1'b0;
      ACT_SET:    result = 1'b1;
      default:    result = level;
    endcase
    return result;
  endfunction

endpackage

`default_nettype wire

### rtl/timer_counter_8bit_normal_ctc_core.sv
`default_nettype none

// Channel   Dir  Signals                        Payload
// s_axis    in   tvalid tready tdata tuser      tuser: func; tdata: ext_pin, write_data
// m_axis    out  tvalid tready tdata            count, flags, compare pins
// cfg       in   cfg_we cfg_index cfg_data      one register write per cycle
//
// One item per cycle sustained while the result is not stalled: an input
// register, one pass of compare and count logic, then the result register.
// Timer state is updated in that same pass, so consecutive ticks follow
// with no bubble. rst is synchronous and clears all timer state and
// configuration. A stalled result holds; the input register still takes
// one more item before s_axis_tready drops.

module timer_counter_8bit_normal_ctc_core
  import tc8_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,

  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] ext_pin, [8:1] write_data, rest zero
  input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,
  // [1:0] func
  input  wire logic [FUNC_BITS-1:0]      s_axis_tuser,

  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [7:0] count_value, [8] overflow_flag, [9] match_a_flag, [10] match_b_flag,
  // [11] pin_a_level, [12] pin_b_level, rest zero
  output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,

  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data
);

  // Configuration registers
  logic [2:0] clock_select;
  logic [2:0] waveform_mode;
  logic [1:0] action_a;
  logic [1:0] action_b;
  logic [7:0] compare_a;
  logic [7:0] compare_b;

  // Input register
  logic        s1_valid;
  func_t       s1_func;
  logic        s1_pin;
  logic [7:0]  s1_data;

  tc8_state_t state;
  tc8_state_t state_next;

  logic stall;
  logic advance;

  assign stall         = m_axis_tvalid && !m_axis_tready;
  assign advance       = s1_valid && !stall;
  assign s_axis_tready = !s1_valid || !stall;

  // Timer step for the item in the input register
  logic halted;
  logic cmp_enable;
  logic match_a;
  logic match_b;
  logic incr;
  logic [PRE_BITS-1:0] pre_inc;

  always_comb begin
    state_next = state;
    pre_inc    = state.prescale + PRE_BITS'(1);
    halted     = (clock_select == CS_STOP) || (waveform_mode == MODE_RSVD_LO) ||
                 (waveform_mode == MODE_RSVD_HI);
    cmp_enable = ((waveform_mode == MODE_NORMAL) || (waveform_mode == MODE_CTC)) &&
                 !state.written_last;
    match_a    = cmp_enable && (state.counter == CNT_BITS'(compare_a));
    match_b    = cmp_enable && (state.counter == CNT_BITS'(compare_b));

    // Increment condition on the advanced prescaler or the pin edge
    case (clock_select)
      CS_DIV1:     incr = 1'b1;
      CS_DIV8:     incr = (pre_inc[2:0] == '0);
      CS_DIV64:    incr = (pre_inc[5:0] == '0);
      CS_DIV256:   incr = (pre_inc[7:0] == '0);
      CS_DIV1024:  incr = (pre_inc == '0);
      CS_EXT_FALL: incr = state.ext_prev && !s1_pin;
      CS_EXT_RISE: incr = !state.ext_prev && s1_pin;
      default:     incr = 1'b0;
    endcase

    unique case (s1_func)
      FUNC_TICK: begin
        state_next.prescale = pre_inc;
        state_next.ext_prev = s1_pin;
        if (!halted) begin
          if (incr) begin
            state_next.counter = state.counter + CNT_BITS'(1);
          end
          if (match_a) begin
            // CTC: clear the count on match A
            if (waveform_mode == MODE_CTC) begin
              state_next.counter = '0;
            end
            state_next.pins[0]       = apply_action(action_a, state.pins[0]);
            state_next.flags[FLAG_MA] = 1'b1;
          end
          if (match_b) begin
            state_next.pins[1]       = apply_action(action_b, state.pins[1]);
            state_next.flags[FLAG_MB] = 1'b1;
          end
          // Overflow is set whenever a running tick leaves zero, advanced or not
          if (state_next.counter == '0) begin
            state_next.flags[FLAG_OVF] = 1'b1;
          end
          state_next.written_last = 1'b0;
        end
      end
      FUNC_WRITE: begin
        // Load the count and skip compares on the next running tick
        state_next.counter      = CNT_BITS'(s1_data);
        state_next.written_last = 1'b1;
      end
      FUNC_FORCE_A: begin
        state_next.pins[0] = apply_action(action_a, state.pins[0]);
      end
      FUNC_FORCE_B: begin
        state_next.pins[1] = apply_action(action_b, state.pins[1]);
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Control state, timer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state         <= '0;
      clock_select  <= CS_STOP;
      waveform_mode <= MODE_NORMAL;
      action_a      <= ACT_NONE;
      action_b      <= ACT_NONE;
      compare_a     <= '0;
      compare_b     <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (!stall) begin
        m_axis_tvalid <= s1_valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLOCK_SELECT: clock_select  <= cfg_data[2:0];
          REG_WAVEFORM:     waveform_mode <= cfg_data[2:0];
          REG_ACTION_A:     action_a      <= cfg_data[1:0];
          REG_ACTION_B:     action_b      <= cfg_data[1:0];
          REG_COMPARE_A:    compare_a     <= cfg_data[7:0];
          REG_COMPARE_B:    compare_b     <= cfg_data[7:0];
          default: begin
            // drop writes to unused indexes
          end
        endcase
      end
    end
  end

  // Payload registers: capture the item on transfer, the result on advance
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_func <= func_t'(s_axis_tuser);
      s1_pin  <= s_axis_tdata[0];
      s1_data <= s_axis_tdata[8:1];
    end
    if (advance) begin
      m_axis_tdata <= {
        (OUT_DATA_BITS - OUT_FIELD_BITS)'(0),
        state_next.pins[1],
        state_next.pins[0],
        state_next.flags[FLAG_MB],
        state_next.flags[FLAG_MA],
        state_next.flags[FLAG_OVF],
        state_next.counter[7:0]
      };
    end
  end

endmodule

`default_nettype wire

### rtl/tc8_checker.sv
`default_nettype none

module tc8_checker
  import tc8_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [OUT_DATA_BITS-1:0]  m_axis_tdata
);

  logic [2:0] seen_flags;
  logic       out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Remember every flag delivered so far
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flags <= '0;
    end else if (out_xfer) begin
      seen_flags <= seen_flags | m_axis_tdata[10:8];
    end
  end

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Flags are sticky across delivered results
  a_flags_sticky: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> ((m_axis_tdata[10:8] & seen_flags) == seen_flags))
    else $error("sticky flag dropped");

  // Input backpressure only appears behind a waiting result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind timer_counter_8bit_normal_ctc_core tc8_checker u_tc8_checker (.*);

`default_nettype wire
